>>> design/fixed_block_pool_allocator_unit_macros.svh
// Assertion shorthands for the pool allocator; clock and reset come from the
// scope that uses them.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FBPA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Expression must never hold.
`define FBPA_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

>>> design/fbpa_pkg.sv
package fbpa_pkg;

   localparam int ADDR_W        = 32;
   localparam int LEN_W         = 16;
   localparam int BLOCKS_FREE_W = 9;
   localparam int IDX_MAX_W     = 16;
   localparam int CSR_IDX_W     = 8;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES  = 8'd1;

   localparam logic [ADDR_W-1:0] RESET_BASE_ADDRESS = 32'd0;
   localparam logic [LEN_W-1:0]  RESET_BLOCK_BYTES  = 16'd4096;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_TOO_BIG  = 2'd2,
      ST_BAD_ADDR = 2'd3
   } status_type;

   // Classified request handed from front to back.
   typedef struct packed {
      cmd_type                command;
      logic                   fault;   // size too big on alloc, bad address on free
      logic [IDX_MAX_W-1:0]   index;   // block index on free
   } fbpa_item_type;

endpackage

>>> design/fbpa_if.sv
interface fbpa_req_if
   import fbpa_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              command;
   logic [ADDR_W-1:0] request_size;
   logic [ADDR_W-1:0] free_address;

   modport source (output valid, command, request_size, free_address, input ready);
   modport sink   (input valid, command, request_size, free_address, output ready);
endinterface

interface fbpa_rsp_if
   import fbpa_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [ADDR_W-1:0]        block_address;
   logic [1:0]               status;
   logic [BLOCKS_FREE_W-1:0] blocks_free;

   modport source (output valid, block_address, status, blocks_free, input ready);
   modport sink   (input valid, block_address, status, blocks_free, output ready);
endinterface

interface fbpa_csr_if
   import fbpa_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ADDR_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/fbpa_div.sv
module fbpa_div
   import fbpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] dividend,
   input  logic [LEN_W-1:0]  divisor,
   output logic              done,
   output logic [ADDR_W-1:0] quotient,
   output logic [LEN_W-1:0]  remainder
);

   localparam int STEP_W = $clog2(ADDR_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [LEN_W:0]    partial;
   logic [LEN_W:0]    trial;
   logic              fits;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      partial = {rem_ff, quo_ff[ADDR_W-1]};
      trial   = partial - {1'b0, divisor};
      fits    = (partial >= {1'b0, divisor});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[ADDR_W-2:0], fits};
         rem_in  = fits ? trial[LEN_W-1:0] : partial[LEN_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(ADDR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> design/fbpa_front.sv
module fbpa_front
   import fbpa_pkg::*;
#(
   parameter int NUM_BLOCKS = 256
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept_en,
   input  logic [ADDR_W-1:0] base_address,
   input  logic [LEN_W-1:0]  block_bytes,
   fbpa_req_if.sink          req_port,
   output logic              push_valid,
   output fbpa_item_type     push_item,
   input  logic              push_ready
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type   state_ff, state_in;
   fbpa_item_type     item_ff, item_in;
   logic              accept;
   logic              div_start;
   logic              div_done;
   logic [ADDR_W-1:0] div_quo;
   logic [LEN_W-1:0]  div_rem;
   logic [ADDR_W-1:0] offset;

   fbpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (offset),
      .divisor   (block_bytes),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_port.ready = (state_ff == F_IDLE) && accept_en;
   assign accept         = req_port.valid && req_port.ready;
   assign offset         = req_port.free_address - base_address;
   assign div_start      = accept && (req_port.command == CMD_FREE);

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_port.command == CMD_FREE) begin
                  item_in.command = CMD_FREE;
                  item_in.fault   = 1'b0;
                  item_in.index   = '0;
                  state_in        = F_DIV;
               end else begin
                  item_in.command = CMD_ALLOC;
                  item_in.fault   = (req_port.request_size > ADDR_W'(block_bytes));
                  item_in.index   = '0;
                  state_in        = F_PUSH;
               end
            end
         end
         F_DIV: begin
            if (div_done) begin
               item_in.fault = (block_bytes == '0) || (div_rem != '0) ||
                               (div_quo >= ADDR_W'(NUM_BLOCKS));
               item_in.index = IDX_MAX_W'(div_quo[IDX_W-1:0]);
               state_in      = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign push_valid = (state_ff == F_PUSH);
   assign push_item  = item_ff;

endmodule

>>> design/fbpa_queue.sv
module fbpa_queue
   import fbpa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  fbpa_item_type push_item,
   output logic          push_ready,
   output logic          pop_valid,
   output fbpa_item_type pop_item,
   input  logic          pop_ready
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   fbpa_item_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop_fire && !push_fire) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/fbpa_back.sv
module fbpa_back
   import fbpa_pkg::*;
#(
   parameter int NUM_BLOCKS = 256
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] base_address,
   input  logic [LEN_W-1:0]  block_bytes,
   input  logic              item_valid,
   input  fbpa_item_type     item,
   output logic              item_ready,
   output logic              clearing,
   fbpa_rsp_if.source        rsp_port
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   typedef enum logic [4:0] {
      B_CLEAR     = 5'b00001,
      B_IDLE      = 5'b00010,
      B_ALLOC_RD  = 5'b00100,
      B_FREE_RD   = 5'b01000,
      B_FREE_LINK = 5'b10000
   } back_state_type;

   back_state_type           state_ff, state_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         clr_ff, clr_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [ADDR_W-1:0]        product_ff, product_in;
   logic                     out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]        out_addr_ff, out_addr_in;
   status_type               out_status_ff, out_status_in;
   logic [BLOCKS_FREE_W-1:0] out_free_ff, out_free_in;
   logic [IDX_W-1:0]         link_mem [NUM_BLOCKS];
   logic [IDX_W-1:0]         link_rd_ff;
   logic                     mem_we;
   logic                     mem_re;
   logic [IDX_W-1:0]         mem_waddr;
   logic [IDX_W-1:0]         mem_wdata;
   logic                     out_open;
   logic                     clr_last;
   logic [IDX_W-1:0]         item_idx;
   logic [CNT_W-1:0]         count_up;
   logic [CNT_W-1:0]         count_dn;

   assign out_open   = !out_valid_ff || rsp_port.ready;
   assign clr_last   = (clr_ff == IDX_W'(NUM_BLOCKS - 1));
   assign item_idx   = item.index[IDX_W-1:0];
   assign count_up   = count_ff + CNT_W'(1);
   assign count_dn   = count_ff - CNT_W'(1);
   assign item_ready = (state_ff == B_IDLE) && out_open;
   assign clearing   = (state_ff == B_CLEAR);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      idx_in        = idx_ff;
      product_in    = product_ff;
      out_valid_in  = out_valid_ff && !rsp_port.ready;
      out_addr_in   = out_addr_ff;
      out_status_in = out_status_ff;
      out_free_in   = out_free_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = head_ff;
      mem_wdata     = idx_ff;
      case (state_ff)
         B_CLEAR: begin
            // Build the initial chain: each block links to the next, last wraps to zero.
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = clr_last ? '0 : clr_ff + IDX_W'(1);
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_last) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (item_valid && out_open) begin
               if (item.command == CMD_ALLOC) begin
                  if (count_ff == '0) begin
                     out_valid_in  = 1'b1;
                     out_addr_in   = '0;
                     out_status_in = ST_EMPTY;
                     out_free_in   = BLOCKS_FREE_W'(count_ff);
                  end else if (item.fault) begin
                     out_valid_in  = 1'b1;
                     out_addr_in   = '0;
                     out_status_in = ST_TOO_BIG;
                     out_free_in   = BLOCKS_FREE_W'(count_ff);
                  end else begin
                     mem_re     = 1'b1;
                     product_in = ADDR_W'(block_bytes) * ADDR_W'(LEN_W'(head_ff));
                     state_in   = B_ALLOC_RD;
                  end
               end else begin
                  if (item.fault || (count_ff == CNT_W'(NUM_BLOCKS))) begin
                     out_valid_in  = 1'b1;
                     out_addr_in   = '0;
                     out_status_in = ST_BAD_ADDR;
                     out_free_in   = BLOCKS_FREE_W'(count_ff);
                  end else if (count_ff == '0) begin
                     head_in       = item_idx;
                     count_in      = count_up;
                     out_valid_in  = 1'b1;
                     out_addr_in   = '0;
                     out_status_in = ST_OK;
                     out_free_in   = BLOCKS_FREE_W'(count_up);
                  end else begin
                     mem_re   = 1'b1;
                     idx_in   = item_idx;
                     state_in = B_FREE_RD;
                  end
               end
            end
         end
         B_ALLOC_RD: begin
            head_in       = link_rd_ff;
            count_in      = count_dn;
            out_valid_in  = 1'b1;
            out_addr_in   = base_address + product_ff;
            out_status_in = ST_OK;
            out_free_in   = BLOCKS_FREE_W'(count_dn);
            state_in      = B_IDLE;
         end
         B_FREE_RD: begin
            mem_we    = 1'b1;
            mem_waddr = head_ff;
            mem_wdata = idx_ff;
            state_in  = B_FREE_LINK;
         end
         B_FREE_LINK: begin
            mem_we        = 1'b1;
            mem_waddr     = idx_ff;
            mem_wdata     = link_rd_ff;
            count_in      = count_up;
            out_valid_in  = 1'b1;
            out_addr_in   = '0;
            out_status_in = ST_OK;
            out_free_in   = BLOCKS_FREE_W'(count_up);
            state_in      = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         head_ff      <= '0;
         count_ff     <= CNT_W'(NUM_BLOCKS);
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      product_ff    <= product_in;
      out_addr_ff   <= out_addr_in;
      out_status_ff <= out_status_in;
      out_free_ff   <= out_free_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         link_rd_ff <= link_mem[head_ff];
      end
   end

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.block_address = out_addr_ff;
   assign rsp_port.status        = out_status_ff;
   assign rsp_port.blocks_free   = out_free_ff;

endmodule

>>> design/fixed_block_pool_allocator_unit.sv
// Fixed-size block pool allocator: hands out and takes back NUM_BLOCKS blocks of
// block_bytes bytes each starting at base_address, keeping free blocks on a linked list
// in an on-chip link memory. Each request beat (allocate or free) yields exactly one
// response beat with the block address, a status and the free-block count. After
// reset the block builds the initial free list and holds req_port.ready low
// meanwhile; CSR writes are taken at any time, but change base_address or block_bytes
// only while no request is in flight. A free passes through the 32-step serial
// divider in the front end that turns the address offset into a block index. A free
// into a non-empty list takes the back end through B_FREE_RD and B_FREE_LINK because
// the link memory has one write port.
`include "fixed_block_pool_allocator_unit_macros.svh"

module fixed_block_pool_allocator_unit
   import fbpa_pkg::*;
#(
   parameter int NUM_BLOCKS = 256
)
(
   input  logic       clock,
   input  logic       reset,
   fbpa_req_if.sink   req_port,
   fbpa_rsp_if.source rsp_port,
   fbpa_csr_if.sink   csr_port
);

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              push_valid;
   fbpa_item_type     push_item;
   logic              push_ready;
   logic              pop_valid;
   fbpa_item_type     pop_item;
   logic              pop_ready;
   logic              clearing;

   // CSR writes are always taken and registered; unknown indexes drop the beat.
   assign csr_port.ready = 1'b1;

   always_comb begin
      base_in = base_ff;
      len_in  = len_ff;
      if (csr_port.valid) begin
         case (csr_port.index)
            CSR_BASE_ADDRESS: base_in = csr_port.data;
            CSR_BLOCK_BYTES:  len_in  = csr_port.data[LEN_W-1:0];
            default: begin
               base_in = base_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= RESET_BASE_ADDRESS;
         len_ff  <= RESET_BLOCK_BYTES;
      end else begin
         base_ff <= base_in;
         len_ff  <= len_in;
      end
   end

   // Front end: accept the beat, check size, divide the offset into a block index.
   fbpa_front #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept_en    (!clearing),
      .base_address (base_ff),
      .block_bytes  (len_ff),
      .req_port     (req_port),
      .push_valid   (push_valid),
      .push_item    (push_item),
      .push_ready   (push_ready)
   );

   // Short queue so the front can start the next divide while the back works.
   fbpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // Back end: walk and relink the free list, hold the response register.
   fbpa_back #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .base_address (base_ff),
      .block_bytes  (len_ff),
      .item_valid   (pop_valid),
      .item         (pop_item),
      .item_ready   (pop_ready),
      .clearing     (clearing),
      .rsp_port     (rsp_port)
   );

   // Only a successful allocate carries an address.
   `FBPA_ASSERT_IMPL(a_fail_zero_addr, rsp_port.valid && (rsp_port.status != ST_OK), rsp_port.block_address == '0, "failed response carries an address")
   // An empty pool report must show no free blocks.
   `FBPA_ASSERT_IMPL(a_empty_no_blocks, rsp_port.valid && (rsp_port.status == ST_EMPTY), rsp_port.blocks_free == '0, "pool empty with free blocks left")
   // No request beat may land while the free list is being built.
   `FBPA_ASSERT_NEVER(a_no_accept_clear, clearing && req_port.valid && req_port.ready, "request accepted during list build")

endmodule
